[src/hsc_pkg.sv]
// shared widths, register map and configuration type of the hatch segment clipper
package hsc_pkg;

	localparam int IDX_W     = 13;
	localparam int SLOPE_W   = 24;
	localparam int SPACE_W   = 28;
	localparam int REG_W     = 12;
	localparam int MODE_W    = 2;
	localparam int DIM_W     = REG_W + 1;
	localparam int QINT_BITS = 20;
	localparam int NUM_W     = DIM_W + SLOPE_W + 1;
	localparam int OFF_W     = DIM_W + SLOPE_W;
	localparam int D_W       = IDX_W + SPACE_W;
	localparam int V_W       = D_W + 2;
	localparam int A_W       = D_W + 1;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int REGSEL_W  = 3;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	localparam logic [MODE_W-1:0] MODE_SHALLOW      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STEEP        = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STEEP_BACK   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SHALLOW_BACK = 2'd3;

	localparam logic [REGSEL_W-1:0] REG_ANGLE_MODE = 3'd0;
	localparam logic [REGSEL_W-1:0] REG_SLOPE      = 3'd1;
	localparam logic [REGSEL_W-1:0] REG_SPACING    = 3'd2;
	localparam logic [REGSEL_W-1:0] REG_LEFT       = 3'd3;
	localparam logic [REGSEL_W-1:0] REG_TOP        = 3'd4;
	localparam logic [REGSEL_W-1:0] REG_RIGHT      = 3'd5;
	localparam logic [REGSEL_W-1:0] REG_BOTTOM     = 3'd6;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [SLOPE_W-1:0] slope;
		logic [SPACE_W-1:0] spacing;
		logic [REG_W-1:0]   left;
		logic [REG_W-1:0]   top;
		logic [REG_W-1:0]   right;
		logic [REG_W-1:0]   bottom;
	} cfg_t;

endpackage

[src/parallel_hatch_segment_clipper.sv]
// top level: register port, front end, queues and clip back end
//
// Returns the clipped endpoints of one line of an equally spaced family of
// parallel lines crossing a rectangular region, one result per request.
// Requests: push a segment_index while full is low; one transfer a cycle.
// Results: while empty is low the oldest result is on start_x..slope_fault,
// and pop takes it. beyond_count marks an index past the family (all other
// fields zero), is_last the final line, slope_fault a clip with zero slope.
// Write the registers over the APB port only while no request is in flight;
// the block itself does not enforce this. Throughput is one segment per cycle
// while nothing stalls. The two restoring dividers give one quotient bit per
// stage over 20 + FRAC_BITS stages.
// A queue between front end and dividers and a result queue let each side
// stall on its own; with pop held low the pipeline freezes and full rises.
// Reset empties everything and loads angle_mode 0, slope 0, spacing 1.0
// and a one-pixel region at the origin.
module parallel_hatch_segment_clipper import hsc_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	input  logic                  push,
	output logic                  full,
	input  logic [IDX_W-1:0]      segment_index,
	output logic                  empty,
	input  logic                  pop,
	output logic [COORD_BITS-1:0] start_x,
	output logic [COORD_BITS-1:0] start_y,
	output logic [COORD_BITS-1:0] end_x,
	output logic [COORD_BITS-1:0] end_y,
	output logic                  is_last,
	output logic                  beyond_count,
	output logic                  slope_fault
);
	localparam int PL_W = REG_W + FRAC_BITS;

	typedef struct packed {
		logic                  clip;
		logic                  sub;
		logic [PL_W-1:0]       plain;
		logic signed [V_W-1:0] other;
		logic [A_W-1:0]        arg;
	} end_t;

	typedef struct packed {
		end_t s;
		end_t e;
		logic xdiv;
		logic last;
		logic beyond;
		logic fault;
	} job_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
		logic                  last;
		logic                  beyond;
		logic                  fault;
	} res_t;

	cfg_t cfg_q;
	logic [REGSEL_W-1:0] regsel;
	logic wr_en;

	logic fr_valid, mid_full, mid_empty, mid_pop;
	job_t fr_job, mid_job;
	logic bk_valid, out_full;
	res_t bk_res, out_res;

	assign pready = 1'b1;
	assign regsel = paddr[APB_AW-1:2];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode    <= MODE_SHALLOW;
			cfg_q.slope   <= '0;
			cfg_q.spacing <= SPACE_W'(1) << FRAC_BITS;
			cfg_q.left    <= '0;
			cfg_q.top     <= '0;
			cfg_q.right   <= '0;
			cfg_q.bottom  <= '0;
		end else if (wr_en) begin
			unique case (regsel)
				REG_ANGLE_MODE: cfg_q.mode    <= pwdata[MODE_W-1:0];
				REG_SLOPE:      cfg_q.slope   <= pwdata[SLOPE_W-1:0];
				REG_SPACING:    cfg_q.spacing <= pwdata[SPACE_W-1:0];
				REG_LEFT:       cfg_q.left    <= pwdata[REG_W-1:0];
				REG_TOP:        cfg_q.top     <= pwdata[REG_W-1:0];
				REG_RIGHT:      cfg_q.right   <= pwdata[REG_W-1:0];
				REG_BOTTOM:     cfg_q.bottom  <= pwdata[REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (regsel)
			REG_ANGLE_MODE: prdata = APB_DW'(cfg_q.mode);
			REG_SLOPE:      prdata = APB_DW'(cfg_q.slope);
			REG_SPACING:    prdata = APB_DW'(cfg_q.spacing);
			REG_LEFT:       prdata = APB_DW'(cfg_q.left);
			REG_TOP:        prdata = APB_DW'(cfg_q.top);
			REG_RIGHT:      prdata = APB_DW'(cfg_q.right);
			REG_BOTTOM:     prdata = APB_DW'(cfg_q.bottom);
			default:        prdata = '0;
		endcase
	end

	hsc_front #(
		.FRAC_BITS(FRAC_BITS),
		.job_t(job_t)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.full(full),
		.segment_index(segment_index),
		.job_valid(fr_valid),
		.job(fr_job),
		.job_full(mid_full)
	);

	hsc_fifo #(
		.DEPTH(MID_DEPTH),
		.item_t(job_t)
	) u_mid_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fr_valid),
		.wdata(fr_job),
		.full(mid_full),
		.pop(mid_pop),
		.rdata(mid_job),
		.empty(mid_empty)
	);

	hsc_back #(
		.FRAC_BITS(FRAC_BITS),
		.COORD_BITS(COORD_BITS),
		.job_t(job_t),
		.res_t(res_t)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job_valid(!mid_empty),
		.job(mid_job),
		.job_pop(mid_pop),
		.res_valid(bk_valid),
		.res(bk_res),
		.res_full(out_full)
	);

	hsc_fifo #(
		.DEPTH(OUT_DEPTH),
		.item_t(res_t)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(bk_valid),
		.wdata(bk_res),
		.full(out_full),
		.pop(pop),
		.rdata(out_res),
		.empty(empty)
	);

	assign start_x      = out_res.start_x;
	assign start_y      = out_res.start_y;
	assign end_x        = out_res.end_x;
	assign end_y        = out_res.end_y;
	assign is_last      = out_res.last;
	assign beyond_count = out_res.beyond;
	assign slope_fault  = out_res.fault;

endmodule

[src/hsc_fifo.sv]
// small first-in first-out queue of generic items
module hsc_fifo #(
	parameter int DEPTH = 2,
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

[src/hsc_front.sv]
// front end: segment offset, count check and clip set-up for both endpoints
module hsc_front import hsc_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter type job_t = logic
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             push,
	output logic             full,
	input  logic [IDX_W-1:0] segment_index,
	output logic             job_valid,
	output job_t             job,
	input  logic             job_full
);
	localparam int PL_W = REG_W + FRAC_BITS;

	logic [DIM_W-1:0]   w, h, dim_a, dim_b;
	logic [SPACE_W-1:0] step;
	logic               xpar, back, adv;
	logic               v_s1, v_s2;
	logic [OFF_W-1:0]   prod_s1;
	logic [D_W-1:0]     d_s1;
	job_t               job_s2;
	job_t               job_n;
	logic [NUM_W-1:0]   num;
	logic [OFF_W-1:0]   off;
	logic [PL_W-1:0]    x1, y1, pbound, qbound;
	logic signed [V_W-1:0] ds, offs, pb, lead, trail, arg_s, arg_e;
	logic               clip_s, clip_e, beyond;

	assign w = (cfg.right >= cfg.left) ?
		(DIM_W'(cfg.right) - DIM_W'(cfg.left) + DIM_W'(1)) : DIM_W'(1);
	assign h = (cfg.bottom >= cfg.top) ?
		(DIM_W'(cfg.bottom) - DIM_W'(cfg.top) + DIM_W'(1)) : DIM_W'(1);
	assign step  = (cfg.spacing == '0) ? SPACE_W'(1) : cfg.spacing;
	assign xpar  = (cfg.mode == MODE_STEEP) || (cfg.mode == MODE_STEEP_BACK);
	assign back  = (cfg.mode == MODE_STEEP_BACK);
	assign dim_a = xpar ? h : w;
	assign dim_b = xpar ? w : h;

	assign adv       = !v_s2 || !job_full;
	assign full      = !adv;
	assign job_valid = v_s2;
	assign job       = job_s2;

	always_comb begin
		num    = NUM_W'(prod_s1) + (NUM_W'(dim_b) << FRAC_BITS);
		off    = prod_s1 - OFF_W'(cfg.slope);
		x1     = PL_W'(w - DIM_W'(1)) << FRAC_BITS;
		y1     = PL_W'(h - DIM_W'(1)) << FRAC_BITS;
		pbound = xpar ? x1 : y1;
		qbound = xpar ? y1 : x1;
		ds     = signed'(V_W'(d_s1));
		offs   = signed'(V_W'(off));
		pb     = signed'(V_W'(pbound));
		beyond = d_s1 > D_W'(num);

		// the leading end moves with the index, the trailing end sits one offset behind
		lead   = back ? ds : pb - ds;
		trail  = back ? ds - offs : lead + offs;
		clip_s = back ? (lead > pb) : (lead < 0);
		clip_e = back ? (trail < 0) : (trail > pb);
		arg_s  = back ? lead - pb : -lead;
		arg_e  = back ? ds : trail - pb;

		job_n          = job_s2;
		job_n.s.clip   = clip_s;
		job_n.s.arg    = arg_s[A_W-1:0];
		job_n.s.other  = clip_s ? (back ? pb : '0) : lead;
		job_n.e.clip   = clip_e;
		job_n.e.arg    = arg_e[A_W-1:0];
		job_n.e.other  = clip_e ? (back ? '0 : pb) : trail;
		if (cfg.mode == MODE_SHALLOW_BACK) begin
			job_n.s.plain = qbound;
			job_n.s.sub   = 1'b1;
			job_n.e.plain = '0;
			job_n.e.sub   = 1'b0;
		end else begin
			job_n.s.plain = '0;
			job_n.s.sub   = 1'b0;
			job_n.e.plain = qbound;
			job_n.e.sub   = !back;
		end
		job_n.xdiv   = !xpar;
		job_n.beyond = beyond;
		job_n.last   = !beyond &&
			((D_W + 1)'(d_s1) + (D_W + 1)'(step) > (D_W + 1)'(num));
		job_n.fault  = (clip_s || clip_e) && (cfg.slope == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= OFF_W'(dim_a) * OFF_W'(cfg.slope);
			d_s1    <= D_W'(segment_index) * D_W'(step);
			job_s2  <= job_n;
		end
	end

endmodule

[src/hsc_back.sv]
// back end: pipelined clip dividers for both endpoints and pixel conversion
module hsc_back import hsc_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_BITS = 12,
	parameter type job_t = logic,
	parameter type res_t = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic job_valid,
	input  job_t job,
	output logic job_pop,
	output logic res_valid,
	output res_t res,
	input  logic res_full
);
	localparam int QB   = QINT_BITS + FRAC_BITS;
	localparam int Q_W  = QB + 1;
	localparam int DC_W = Q_W + 1;
	localparam int PX_W = (V_W > DC_W) ? V_W : DC_W;
	localparam int NS   = QB;
	localparam int REM_W = SLOPE_W + 1;

	typedef struct packed {
		logic [SLOPE_W-1:0]   rem;
		logic [QB-1:0]        q;
		logic [QINT_BITS-1:0] lo;
		logic                 sat;
	} div_t;

	typedef struct packed {
		job_t                  job;
		div_t                  dvs;
		div_t                  dve;
		logic [COORD_BITS-1:0] os;
		logic [COORD_BITS-1:0] oe;
	} stg_t;

	function automatic div_t div_init(input logic [A_W-1:0] arg, input logic [SLOPE_W-1:0] sl);
		logic [A_W-1:0] hi;
		div_t d;
		hi    = arg >> QINT_BITS;
		d.sat = hi >= A_W'(sl);
		d.rem = SLOPE_W'(hi);
		d.lo  = arg[QINT_BITS-1:0];
		d.q   = '0;
		return d;
	endfunction

	function automatic div_t div_step(input div_t d, input logic [SLOPE_W-1:0] sl);
		logic [REM_W-1:0] r2;
		logic ge;
		div_t n;
		r2    = {d.rem, d.lo[QINT_BITS-1]};
		ge    = r2 >= REM_W'(sl);
		n.rem = ge ? SLOPE_W'(r2 - REM_W'(sl)) : SLOPE_W'(r2);
		n.q   = {d.q[QB-2:0], ge};
		n.lo  = d.lo << 1;
		n.sat = d.sat;
		return n;
	endfunction

	// truncate toward zero to a whole pixel and add the origin, wrapping
	function automatic logic [COORD_BITS-1:0] to_pix(input logic signed [PX_W-1:0] v,
	                                                 input logic [REG_W-1:0] org);
		logic signed [PX_W-1:0] mag;
		logic [COORD_BITS-1:0] t;
		mag = (v < 0) ? -v : v;
		t   = mag[FRAC_BITS +: COORD_BITS];
		if (v < 0) begin
			t = -t;
		end
		return t + COORD_BITS'(org);
	endfunction

	stg_t              pipe_q [NS+1];
	logic [NS:0]       v_q;
	logic              adv;
	stg_t              entry;
	stg_t              last;
	logic [Q_W-1:0]    qs, qe;
	logic signed [DC_W-1:0] dcs, dce;
	logic [COORD_BITS-1:0]  ps, pe;
	logic [REG_W-1:0]  org_oth;

	assign adv       = !v_q[NS] || !res_full;
	assign job_pop   = adv && job_valid;
	assign res_valid = v_q[NS];
	assign org_oth   = job.xdiv ? cfg.top : cfg.left;

	always_comb begin
		entry.job = job;
		entry.dvs = div_init(job.s.arg, cfg.slope);
		entry.dve = div_init(job.e.arg, cfg.slope);
		entry.os  = to_pix(PX_W'(job.s.other), org_oth);
		entry.oe  = to_pix(PX_W'(job.e.other), org_oth);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-1:0], job_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_q[0] <= entry;
			for (int i = 0; i < NS; i++) begin
				pipe_q[i+1].job <= pipe_q[i].job;
				pipe_q[i+1].os  <= pipe_q[i].os;
				pipe_q[i+1].oe  <= pipe_q[i].oe;
				pipe_q[i+1].dvs <= div_step(pipe_q[i].dvs, cfg.slope);
				pipe_q[i+1].dve <= div_step(pipe_q[i].dve, cfg.slope);
			end
		end
	end

	always_comb begin
		last = pipe_q[NS];
		// zero slope gives a zero quotient, a huge one saturates
		qs = (cfg.slope == '0) ? '0 :
			(last.dvs.sat ? (Q_W'(1) << QB) : Q_W'(last.dvs.q));
		qe = (cfg.slope == '0) ? '0 :
			(last.dve.sat ? (Q_W'(1) << QB) : Q_W'(last.dve.q));
		dcs = signed'(DC_W'(last.job.s.plain));
		if (last.job.s.clip) begin
			dcs = last.job.s.sub ? dcs - signed'(DC_W'(qs)) : signed'(DC_W'(qs));
		end
		dce = signed'(DC_W'(last.job.e.plain));
		if (last.job.e.clip) begin
			dce = last.job.e.sub ? dce - signed'(DC_W'(qe)) : signed'(DC_W'(qe));
		end
		ps = to_pix(PX_W'(dcs), last.job.xdiv ? cfg.left : cfg.top);
		pe = to_pix(PX_W'(dce), last.job.xdiv ? cfg.left : cfg.top);

		if (last.job.beyond) begin
			res.start_x = '0;
			res.start_y = '0;
			res.end_x   = '0;
			res.end_y   = '0;
			res.last    = 1'b0;
			res.fault   = 1'b0;
		end else begin
			res.start_x = last.job.xdiv ? ps : last.os;
			res.start_y = last.job.xdiv ? last.os : ps;
			res.end_x   = last.job.xdiv ? pe : last.oe;
			res.end_y   = last.job.xdiv ? last.oe : pe;
			res.last    = last.job.last;
			res.fault   = last.job.fault;
		end
		res.beyond = last.job.beyond;
	end

endmodule

[sim/hsc_checker.sv]
// checker for the hatch segment clipper: register shadow, segment predictor and result compare
module hsc_checker import hsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              push,
	input  logic              full,
	input  logic [IDX_W-1:0]  segment_index,
	input  logic              empty,
	input  logic              pop,
	input  logic [11:0]       start_x,
	input  logic [11:0]       start_y,
	input  logic [11:0]       end_x,
	input  logic [11:0]       end_y,
	input  logic              is_last,
	input  logic              beyond_count,
	input  logic              slope_fault,
	output int                pending,
	output int                errors,
	output longint            family_size
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;

	typedef struct packed {
		logic [11:0] sx;
		logic [11:0] sy;
		logic [11:0] ex;
		logic [11:0] ey;
		logic        last;
		logic        beyond;
		logic        fault;
	} segment_t;

	cfg_t     cfg;
	segment_t segments_due[$];

	function automatic longint width_px(logic [11:0] lo, logic [11:0] hi);
		return (hi >= lo) ? longint'(hi) - longint'(lo) + 1 : 1;
	endfunction

	function automatic longint line_count();
		longint w, h, step, num;
		w = width_px(cfg.left, cfg.right);
		h = width_px(cfg.top, cfg.bottom);
		step = (cfg.spacing == 0) ? 1 : longint'(cfg.spacing);
		if (cfg.mode == MODE_STEEP || cfg.mode == MODE_STEEP_BACK)
			num = h * longint'(cfg.slope) + (w << FB);
		else
			num = w * longint'(cfg.slope) + (h << FB);
		return num / step + 1;
	endfunction

	function automatic longint slope_quot(longint a, inout bit flt);
		longint ua, qi, r, s;
		ua = (a < 0) ? 0 : a;
		s = longint'(cfg.slope);
		if (s == 0) begin
			flt = 1'b1;
			return 0;
		end
		qi = ua / s;
		r = ua % s;
		if (qi >= (longint'(1) << 20))
			return longint'(1) << (20 + FB);
		return (qi << FB) + ((r << FB) / s);
	endfunction

	function automatic logic [11:0] to_px(longint v, logic [11:0] org);
		longint t;
		t = (v >= 0) ? (v >> FB) : -((-v) >> FB);
		return 12'(t + longint'(org));
	endfunction

	function automatic segment_t clip_segment(logic [IDX_W-1:0] idx);
		segment_t res;
		longint w, h, cnt, x1, y1, off, d, xs, ys, xe, ye;
		bit flt;
		flt = 1'b0;
		res = '0;
		w = width_px(cfg.left, cfg.right);
		h = width_px(cfg.top, cfg.bottom);
		cnt = line_count();
		x1 = (w - 1) << FB;
		y1 = (h - 1) << FB;
		if (cfg.mode == MODE_STEEP || cfg.mode == MODE_STEEP_BACK)
			off = (h - 1) * longint'(cfg.slope);
		else
			off = (w - 1) * longint'(cfg.slope);
		d = longint'(idx) * ((cfg.spacing == 0) ? 1 : longint'(cfg.spacing));
		if (longint'(idx) >= cnt) begin
			res.beyond = 1'b1;
			return res;
		end
		case (cfg.mode)
			MODE_SHALLOW: begin
				ys = y1 - d;
				ye = ys + off;
				if (ys < 0) begin
					xs = slope_quot(-ys, flt);
					ys = 0;
				end else xs = 0;
				if (ye > y1) begin
					xe = x1 - slope_quot(ye - y1, flt);
					ye = y1;
				end else xe = x1;
			end
			MODE_STEEP: begin
				xs = x1 - d;
				xe = xs + off;
				if (xs < 0) begin
					ys = slope_quot(-xs, flt);
					xs = 0;
				end else ys = 0;
				if (xe > x1) begin
					ye = y1 - slope_quot(xe - x1, flt);
					xe = x1;
				end else ye = y1;
			end
			MODE_STEEP_BACK: begin
				xs = d;
				xe = d - off;
				if (xs > x1) begin
					ys = slope_quot(xs - x1, flt);
					xs = x1;
				end else ys = 0;
				// end row is clipped from the unclamped start column
				if (xe < 0) begin
					ye = slope_quot(d, flt);
					xe = 0;
				end else ye = y1;
			end
			default: begin
				ys = y1 - d;
				ye = ys + off;
				if (ys < 0) begin
					xs = x1 - slope_quot(-ys, flt);
					ys = 0;
				end else xs = x1;
				if (ye > y1) begin
					xe = slope_quot(ye - y1, flt);
					ye = y1;
				end else xe = 0;
			end
		endcase
		res.sx = to_px(xs, cfg.left);
		res.sy = to_px(ys, cfg.top);
		res.ex = to_px(xe, cfg.left);
		res.ey = to_px(ye, cfg.top);
		res.last = (longint'(idx) == cnt - 1);
		res.fault = flt;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	always_comb family_size = line_count();

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mode <= MODE_SHALLOW;
			cfg.slope <= '0;
			cfg.spacing <= SPACE_W'(1 << FB);
			cfg.left <= '0;
			cfg.top <= '0;
			cfg.right <= '0;
			cfg.bottom <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[4:2])
				REG_ANGLE_MODE: cfg.mode <= pwdata[MODE_W-1:0];
				REG_SLOPE:      cfg.slope <= pwdata[SLOPE_W-1:0];
				REG_SPACING:    cfg.spacing <= pwdata[SPACE_W-1:0];
				REG_LEFT:       cfg.left <= pwdata[11:0];
				REG_TOP:        cfg.top <= pwdata[11:0];
				REG_RIGHT:      cfg.right <= pwdata[11:0];
				REG_BOTTOM:     cfg.bottom <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		segment_t want;
		if (arst_n && push && !full)
			segments_due.push_back(clip_segment(segment_index));
		if (arst_n && pop && !empty) begin
			if (segments_due.size() == 0) begin
				$display("result transfer with nothing outstanding");
				errors++;
			end else begin
				want = segments_due.pop_front();
				if (start_x != want.sx) report_mismatch("start_x", start_x, want.sx);
				if (start_y != want.sy) report_mismatch("start_y", start_y, want.sy);
				if (end_x != want.ex) report_mismatch("end_x", end_x, want.ex);
				if (end_y != want.ey) report_mismatch("end_y", end_y, want.ey);
				if (is_last != want.last) report_mismatch("is_last", is_last, want.last);
				if (beyond_count != want.beyond)
					report_mismatch("beyond_count", beyond_count, want.beyond);
				if (slope_fault != want.fault)
					report_mismatch("slope_fault", slope_fault, want.fault);
			end
		end
		pending = segments_due.size();
	end
endmodule

[sim/tb_parallel_hatch_segment_clipper.sv]
// testbench top for the hatch segment clipper: stimulus, register phases and verdict
module tb_parallel_hatch_segment_clipper;
	import hsc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOTAL_ITEMS = 1050;
	localparam int CYCLE_LIMIT = 600000;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;
	logic pready, push, full, empty, pop;
	logic [IDX_W-1:0] segment_index;
	logic [11:0] start_x, start_y, end_x, end_y;
	logic is_last, beyond_count, slope_fault;
	int pending, errors, sent;
	longint family_size;
	int cycles;
	bit quiet, hold_go;

	parallel_hatch_segment_clipper u_top (.*);

	hsc_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("** parallel_hatch_segment_clipper: FAILED **");
				$finish;
			end
		end
	end

	// result side: random stall bursts, one long hold-off to fill the pipeline
	initial begin
		bit held;
		held = 1'b0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_go && !held) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic reg_write(logic [REGSEL_W-1:0] sel, logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(sel) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_region(int mode, int slp, int spc, int l, int t, int r, int b);
		reg_write(REG_ANGLE_MODE, mode);
		reg_write(REG_SLOPE, slp);
		reg_write(REG_SPACING, spc);
		reg_write(REG_LEFT, l);
		reg_write(REG_TOP, t);
		reg_write(REG_RIGHT, r);
		reg_write(REG_BOTTOM, b);
		@(posedge clk);
	endtask

	task automatic send_index(logic [IDX_W-1:0] idx);
		push <= 1'b1;
		segment_index <= idx;
		do @(posedge clk); while (full);
		sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		longint hi;
		hi = (family_size + 1 > 8191) ? 8191 : family_size + 1;
		case ($urandom_range(0, 9))
			0: return IDX_W'($urandom);
			1: return IDX_W'((family_size > 8191) ? 8191 : family_size - 1);
			default: return IDX_W'($urandom_range(0, int'(hi)));
		endcase
	endfunction

	function automatic int pick_slope();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 24'hFFFFFF;
			2: return $urandom_range(1, 1 << 17);
			3: return $urandom_range(1 << 10, 1 << 20);
			default: return $urandom & 24'hFFFFFF;
		endcase
	endfunction

	function automatic int pick_spacing();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 28'hFFFFFFF;
			2: return $urandom & 28'hFFFFFFF;
			3: return $urandom_range(1, 1 << 14);
			default: return $urandom_range(1 << 16, 1 << 23);
		endcase
	endfunction

	initial begin
		int lo, top_row, hi, bot;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		segment_index = '0;
		quiet = 1'b0;
		hold_go = 1'b0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings, then the corners of the register space
		send_index(0);
		send_index(1);
		send_index(2);
		send_index(13'h1FFF);
		drain();
		load_region(MODE_SHALLOW, 24'hFFFFFF, 28'hFFFFFFF, 4095, 4095, 4095, 4095);
		send_index(0);
		send_index(1);
		send_index(13'h1FFF);
		drain();
		load_region(MODE_STEEP, 0, 1 << 16, 0, 0, 4095, 4095);
		send_index(0);
		send_index(4095);
		send_index(8191);
		drain();
		load_region(MODE_STEEP_BACK, 1 << 16, 0, 0, 0, 4095, 4095);
		send_index(0);
		send_index(5000);
		send_index(8191);
		drain();
		load_region(MODE_SHALLOW_BACK, 1 << 15, 1 << 18, 100, 200, 50, 40);
		send_index(0);
		send_index(1);
		send_index(2);
		drain();
		load_region(MODE_STEEP_BACK, 0, 1 << 17, 10, 10, 40, 40);
		send_index(0);
		send_index(15);
		send_index(30);
		drain();

		while (sent < TOTAL_ITEMS) begin
			lo = $urandom_range(0, 4095);
			top_row = $urandom_range(0, 4095);
			case ($urandom_range(0, 4))
				0: begin
					hi = $urandom_range(0, 4095);
					bot = $urandom_range(0, 4095);
				end
				1: begin
					hi = lo - 1;
					bot = top_row + $urandom_range(0, 30);
				end
				default: begin
					hi = lo + $urandom_range(0, 80);
					bot = top_row + $urandom_range(0, 80);
				end
			endcase
			load_region($urandom_range(0, 3), pick_slope(), pick_spacing(), lo,
				top_row, hi & 12'hFFF, bot & 12'hFFF);
			if (sent > TOTAL_ITEMS * 85 / 100)
				quiet = 1'b1;
			if (sent > 200 && !hold_go) begin
				hold_go <= 1'b1;
				// more items than every stage and queue can hold while the receiver waits
				repeat (100) send_index(pick_index());
			end else begin
				repeat ($urandom_range(30, 60)) send_index(pick_index());
			end
			drain();
		end

		if (errors == 0)
			$display("** parallel_hatch_segment_clipper: PASSED **");
		else
			$display("** parallel_hatch_segment_clipper: FAILED **");
		$finish;
	end
endmodule

[files.f]
src/hsc_pkg.sv
src/hsc_fifo.sv
src/hsc_front.sv
src/hsc_back.sv
src/parallel_hatch_segment_clipper.sv
sim/hsc_checker.sv
sim/tb_parallel_hatch_segment_clipper.sv
